/* rtl/qau_pkg.sv */
package qau_pkg;

    localparam int DEF_FRAC_BITS = 16;

    typedef enum logic [1:0] {
        MODE_MUL  = 2'd0,
        MODE_ROT  = 2'd1,
        MODE_NORM = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    localparam logic signed [66:0] SAT_HI = 67'sd2147483647;
    localparam logic signed [66:0] SAT_LO = -67'sd2147483648;

    // Per-request data that rides alongside the square root and divider.
    typedef struct packed {
        logic             norm;   // normalize with nonzero length: result from divider
        logic             zl;
        logic             sat;
        logic [3:0]       neg;    // signs of a
        logic [3:0][31:0] res;    // final result unless norm
        logic [3:0][30:0] mag;    // scaled magnitudes of a
    } t_side;

endpackage

/* rtl/quaternion_arithmetic_unit_top.sv */
// Channel   Direction  Handshake          Payload
// -------   ---------  -----------------  -----------------------------------------
// request   in         i_valid / o_stall  i_mode, i_a_w..i_a_z, i_b_w..i_b_z
// result    out        o_valid / i_stall  o_r_w..o_r_z, o_zero_length, o_saturated
//
// One request enters per cycle unless o_stall is high; the pipe holds the 32 one-bit
// square root steps and FRAC_BITS + 1 divider steps (Q16.16 by default).
// Reset (i_rst_n low, synchronous) clears only the valid bits of the pipeline.
// All stages share one enable: the pipe advances unless the last stage holds a
// result that is stalled, so a stall holds every request in place.
module quaternion_arithmetic_unit_top
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_a_w,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_w,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_r_w,
    output logic signed [31:0] o_r_x,
    output logic signed [31:0] o_r_y,
    output logic signed [31:0] o_r_z,
    output logic               o_zero_length,
    output logic               o_saturated
);

    localparam int F  = FRAC_BITS;
    localparam int NW = 32 + F;     // divider numerator width
    localparam int QW = F + 1;      // quotient width, quotient <= 2^F
    localparam int NP = 35 + F;     // stages after the front end
    localparam int NL = 6 + NP;     // total stages

    // Round to nearest, ties up: floor((s + half) / 2^F).
    function automatic logic signed [66:0] f_rnd(input logic signed [66:0] s);
        return (s + (67'sd1 <<< (F - 1))) >>> F;
    endfunction

    // {clipped, value}
    function automatic logic [32:0] f_sat(input logic signed [66:0] x);
        if (x > SAT_HI) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (x < SAT_LO) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, x[31:0]};
    endfunction

    logic            adv;
    logic [NL-1:0]   r_vld;

    assign adv     = !r_vld[NL-1] || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_vld[NL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NL-2:0], i_valid};
        end
    end

    // ---------------- S1: input register
    t_mode            r_s1_mode;
    logic [3:0][31:0] r_s1_a, r_s1_b;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_mode <= t_mode'(i_mode);
            r_s1_a    <= {i_a_z, i_a_y, i_a_x, i_a_w};
            r_s1_b    <= {i_b_z, i_b_y, i_b_x, i_b_w};
        end
    end

    // ---------------- S2: products of a*b and of a's own parts, magnitudes
    t_mode              r_s2_mode;
    logic [3:0][31:0]   r_s2_a, r_s2_b;
    logic signed [63:0] r_s2_ab [4][4];
    logic signed [63:0] r_s2_k [9];
    logic [3:0][31:0]   r_s2_u;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_mode <= r_s1_mode;
            r_s2_a    <= r_s1_a;
            r_s2_b    <= r_s1_b;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_s2_ab[i][j] <= 64'($signed(r_s1_a[i])) * 64'($signed(r_s1_b[j]));
                end
                r_s2_u[i] <= r_s1_a[i][31] ? (~r_s1_a[i] + 32'd1) : r_s1_a[i];
            end
            // xx yy zz xy wz wy xz yz wx
            r_s2_k[0] <= 64'($signed(r_s1_a[1])) * 64'($signed(r_s1_a[1]));
            r_s2_k[1] <= 64'($signed(r_s1_a[2])) * 64'($signed(r_s1_a[2]));
            r_s2_k[2] <= 64'($signed(r_s1_a[3])) * 64'($signed(r_s1_a[3]));
            r_s2_k[3] <= 64'($signed(r_s1_a[1])) * 64'($signed(r_s1_a[2]));
            r_s2_k[4] <= 64'($signed(r_s1_a[0])) * 64'($signed(r_s1_a[3]));
            r_s2_k[5] <= 64'($signed(r_s1_a[0])) * 64'($signed(r_s1_a[2]));
            r_s2_k[6] <= 64'($signed(r_s1_a[1])) * 64'($signed(r_s1_a[3]));
            r_s2_k[7] <= 64'($signed(r_s1_a[2])) * 64'($signed(r_s1_a[3]));
            r_s2_k[8] <= 64'($signed(r_s1_a[0])) * 64'($signed(r_s1_a[1]));
        end
    end

    // ---------------- S3: product sums, rotation matrix, max magnitude
    logic [32:0]      n_s3_q0 [4];
    logic [32:0]      n_s3_m [9];
    logic [31:0]      n_s3_mx01, n_s3_mx23, n_s3_mx;

    always_comb begin
        n_s3_q0[0] = f_sat(f_rnd(67'(r_s2_ab[0][0]) - 67'(r_s2_ab[1][1])
                               - 67'(r_s2_ab[2][2]) - 67'(r_s2_ab[3][3])));
        n_s3_q0[1] = f_sat(f_rnd(67'(r_s2_ab[1][0]) + 67'(r_s2_ab[0][1])
                               + 67'(r_s2_ab[2][3]) - 67'(r_s2_ab[3][2])));
        n_s3_q0[2] = f_sat(f_rnd(67'(r_s2_ab[2][0]) + 67'(r_s2_ab[0][2])
                               + 67'(r_s2_ab[3][1]) - 67'(r_s2_ab[1][3])));
        n_s3_q0[3] = f_sat(f_rnd(67'(r_s2_ab[3][0]) + 67'(r_s2_ab[0][3])
                               + 67'(r_s2_ab[1][2]) - 67'(r_s2_ab[2][1])));
        n_s3_m[0] = f_sat(f_rnd(-67'(r_s2_k[1]) - 67'(r_s2_k[2])));
        n_s3_m[1] = f_sat(f_rnd(67'(r_s2_k[3]) - 67'(r_s2_k[4])));
        n_s3_m[2] = f_sat(f_rnd(67'(r_s2_k[5]) + 67'(r_s2_k[6])));
        n_s3_m[3] = f_sat(f_rnd(67'(r_s2_k[4]) + 67'(r_s2_k[3])));
        n_s3_m[4] = f_sat(f_rnd(-67'(r_s2_k[0]) - 67'(r_s2_k[2])));
        n_s3_m[5] = f_sat(f_rnd(67'(r_s2_k[7]) - 67'(r_s2_k[8])));
        n_s3_m[6] = f_sat(f_rnd(67'(r_s2_k[6]) - 67'(r_s2_k[5])));
        n_s3_m[7] = f_sat(f_rnd(67'(r_s2_k[8]) + 67'(r_s2_k[7])));
        n_s3_m[8] = f_sat(f_rnd(-67'(r_s2_k[0]) - 67'(r_s2_k[1])));
        n_s3_mx01 = (r_s2_u[0] > r_s2_u[1]) ? r_s2_u[0] : r_s2_u[1];
        n_s3_mx23 = (r_s2_u[2] > r_s2_u[3]) ? r_s2_u[2] : r_s2_u[3];
        n_s3_mx   = (n_s3_mx01 > n_s3_mx23) ? n_s3_mx01 : n_s3_mx23;
    end

    t_mode              r_s3_mode;
    logic [3:0][31:0]   r_s3_a, r_s3_b, r_s3_u, r_s3_q0;
    logic signed [31:0] r_s3_m [9];
    logic               r_s3_sat0, r_s3_sat1;
    logic [31:0]        r_s3_mx;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_mode <= r_s2_mode;
            r_s3_a    <= r_s2_a;
            r_s3_b    <= r_s2_b;
            r_s3_u    <= r_s2_u;
            r_s3_mx   <= n_s3_mx;
            for (int i = 0; i < 4; i++) begin
                r_s3_q0[i] <= n_s3_q0[i][31:0];
            end
            for (int i = 0; i < 9; i++) begin
                r_s3_m[i] <= n_s3_m[i][31:0];
            end
            r_s3_sat0 <= n_s3_q0[0][32] | n_s3_q0[1][32] | n_s3_q0[2][32] | n_s3_q0[3][32];
            r_s3_sat1 <= n_s3_m[0][32] | n_s3_m[1][32] | n_s3_m[2][32] | n_s3_m[3][32]
                       | n_s3_m[4][32] | n_s3_m[5][32] | n_s3_m[6][32] | n_s3_m[7][32]
                       | n_s3_m[8][32];
        end
    end

    // ---------------- S4: matrix * vector products, magnitude scaling
    logic [4:0]       n_s4_pos;
    logic [4:0]       n_s4_sh;
    logic [3:0][30:0] n_s4_v;

    always_comb begin
        n_s4_pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_s3_mx[i]) begin
                n_s4_pos = 5'(i);
            end
        end
        n_s4_sh = 5'd30 - n_s4_pos;
        for (int i = 0; i < 4; i++) begin
            // a top magnitude of 2^31 halves everything, else shift up to [2^30, 2^31)
            n_s4_v[i] = r_s3_mx[31] ? 31'(r_s3_u[i] >> 1) : 31'(r_s3_u[i] << n_s4_sh);
        end
    end

    t_mode              r_s4_mode;
    logic [3:0][31:0]   r_s4_a, r_s4_b, r_s4_q0;
    logic               r_s4_sat0, r_s4_sat1, r_s4_zl;
    logic signed [63:0] r_s4_rp [9];
    logic [3:0][30:0]   r_s4_v;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_mode <= r_s3_mode;
            r_s4_a    <= r_s3_a;
            r_s4_b    <= r_s3_b;
            r_s4_q0   <= r_s3_q0;
            r_s4_sat0 <= r_s3_sat0;
            r_s4_sat1 <= r_s3_sat1;
            r_s4_zl   <= (r_s3_mx == 32'd0);
            r_s4_v    <= n_s4_v;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s4_rp[r*3+c] <= 64'(r_s3_m[r*3+c]) * 64'($signed(r_s3_b[c+1]));
                end
            end
        end
    end

    // ---------------- S5: rotated rows, squares of scaled magnitudes
    logic [32:0] n_s5_row [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_s5_row[r] = f_sat((f_rnd(67'(r_s4_rp[r*3]) + 67'(r_s4_rp[r*3+1])
                                     + 67'(r_s4_rp[r*3+2])) <<< 1)
                                + 67'($signed(r_s4_b[r+1])));
        end
    end

    t_mode            r_s5_mode;
    logic [3:0][31:0] r_s5_a, r_s5_q0;
    logic             r_s5_sat0, r_s5_sat2, r_s5_zl;
    logic [2:0][31:0] r_s5_rw;
    logic [61:0]      r_s5_sq [4];
    logic [3:0][30:0] r_s5_v;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s5_mode <= r_s4_mode;
            r_s5_a    <= r_s4_a;
            r_s5_q0   <= r_s4_q0;
            r_s5_sat0 <= r_s4_sat0;
            r_s5_sat2 <= r_s4_sat1 | n_s5_row[0][32] | n_s5_row[1][32] | n_s5_row[2][32];
            r_s5_zl   <= r_s4_zl;
            r_s5_v    <= r_s4_v;
            for (int r = 0; r < 3; r++) begin
                r_s5_rw[r] <= n_s5_row[r][31:0];
            end
            for (int i = 0; i < 4; i++) begin
                r_s5_sq[i] <= 62'(r_s4_v[i]) * 62'(r_s4_v[i]);
            end
        end
    end

    // ---------------- S6: result select, sum of squares
    t_side n_s6_side;

    always_comb begin
        n_s6_side      = '0;
        n_s6_side.mag  = r_s5_v;
        n_s6_side.res  = r_s5_a;
        for (int i = 0; i < 4; i++) begin
            n_s6_side.neg[i] = r_s5_a[i][31];
        end
        case (r_s5_mode)
            MODE_MUL: begin
                n_s6_side.res = r_s5_q0;
                n_s6_side.sat = r_s5_sat0;
            end
            MODE_ROT: begin
                n_s6_side.res = {r_s5_rw, 32'd0};
                n_s6_side.sat = r_s5_sat2;
            end
            MODE_NORM: begin
                n_s6_side.zl   = r_s5_zl;
                n_s6_side.norm = !r_s5_zl;
            end
            default: begin
                n_s6_side.res = r_s5_a;
            end
        endcase
    end

    t_side       r_s6_side;
    logic [63:0] r_s6_sum;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s6_side <= n_s6_side;
            r_s6_sum  <= 64'(r_s5_sq[0]) + 64'(r_s5_sq[1]) + 64'(r_s5_sq[2])
                       + 64'(r_s5_sq[3]);
        end
    end

    // ---------------- side data delay line
    t_side r_sd [NP-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd[0] <= r_s6_side;
            for (int p = 1; p < NP - 1; p++) begin
                r_sd[p] <= r_sd[p-1];
            end
        end
    end

    // ---------------- square root, one root bit per stage
    logic [63:0] r_sq_rem [31];
    logic [31:0] r_sq_root [32];

    for (genvar p = 0; p < 32; p++) begin : g_sq
        localparam int BIT = 31 - p;
        logic [63:0] rem_in;
        logic [31:0] root_in;
        logic [65:0] trial;
        logic        take;

        if (p == 0) begin : g_first
            assign rem_in  = r_s6_sum;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_sq_rem[p-1];
            assign root_in = r_sq_root[p-1];
        end

        // (root + 2^BIT)^2 - root^2
        assign trial = (66'(root_in) << (BIT + 1)) + (66'(1) << (2 * BIT));
        assign take  = 66'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_root[p] <= take ? (root_in | (32'(1) << BIT)) : root_in;
            end
        end

        if (p < 31) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_sq_rem[p] <= take ? (rem_in - trial[63:0]) : rem_in;
                end
            end
        end
    end

    // ---------------- divider: numerator, then one quotient bit per stage
    logic [3:0][NW-1:0] r_dv_rem [F+1];
    logic [31:0]        r_dv_rt [F+1];
    logic [3:0][QW-1:0] r_dv_q [F+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_rt[0] <= r_sq_root[31];
            for (int l = 0; l < 4; l++) begin
                r_dv_rem[0][l] <= (NW'(r_sd[31].mag[l]) << F) + NW'(r_sq_root[31] >> 1);
            end
        end
    end

    for (genvar d = 1; d <= F + 1; d++) begin : g_dv
        localparam int K = F + 1 - d;
        logic [3:0][QW-1:0] q_in;
        logic [NW-1:0]      dvs;
        logic [3:0]         take;

        if (d == 1) begin : g_first
            assign q_in = '0;
        end else begin : g_next
            assign q_in = r_dv_q[d-2];
        end

        assign dvs = NW'(r_dv_rt[d-1]) << K;

        for (genvar l = 0; l < 4; l++) begin : g_lane
            assign take[l] = r_dv_rem[d-1][l] >= dvs;

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dv_q[d-1][l] <= {q_in[l][QW-2:0], take[l]};
                end
            end

            if (d <= F) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        r_dv_rem[d][l] <= take[l] ? (r_dv_rem[d-1][l] - dvs)
                                                  : r_dv_rem[d-1][l];
                    end
                end
            end
        end

        if (d <= F) begin : g_rt
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dv_rt[d] <= r_dv_rt[d-1];
                end
            end
        end
    end

    // ---------------- output register
    logic [3:0][31:0] r_o_res;
    logic             r_o_zl, r_o_sat;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_zl  <= r_sd[NP-2].zl;
            r_o_sat <= r_sd[NP-2].sat;
            for (int i = 0; i < 4; i++) begin
                if (r_sd[NP-2].norm) begin
                    r_o_res[i] <= r_sd[NP-2].neg[i] ? (32'd0 - 32'(r_dv_q[F][i]))
                                                    : 32'(r_dv_q[F][i]);
                end else begin
                    r_o_res[i] <= r_sd[NP-2].res[i];
                end
            end
        end
    end

    assign o_r_w         = r_o_res[0];
    assign o_r_x         = r_o_res[1];
    assign o_r_y         = r_o_res[2];
    assign o_r_z         = r_o_res[3];
    assign o_zero_length = r_o_zl;
    assign o_saturated   = r_o_sat;

endmodule
